// File: hdl/ona_pkg.sv
package ona_pkg;

    typedef enum logic [1:0] {
        FUNC_GEN    = 2'd0,
        FUNC_BIND   = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic gen_step;
    } ona_cmd_t;

    typedef struct packed {
        logic run_gen;
        logic gen_end;
    } ona_sts_t;

    typedef struct packed {
        logic [7:0] out_name;
        status_t    status;
        logic       is_live;
        logic       last;
    } ona_res_t;

endpackage

// File: hdl/object_name_allocator.sv
// bind, delete and query: accepted, executed the next cycle, result beat on the
// ports the cycle after; a new command is taken only while busy is low
// generate of n names: an exec setup step, then one result beat per cycle (n beats, or
// fewer plus a full beat), set by the one-pop-per-cycle free stack ram read
// reset: names 0 and 1 live, high-water 2, current name 1, free stack empty
// results cannot be stalled; each beat is valid for exactly one cycle
module object_name_allocator
    import ona_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int MAX_BATCH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [7:0] name,
    input  logic [4:0] count,
    output logic       strobe,
    output logic [7:0] out_name,
    output logic [1:0] status,
    output logic       is_live,
    output logic [7:0] current_name,
    output logic       last
);

    ona_cmd_t cmd;
    ona_sts_t sts;

    ona_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .sts  (sts),
        .cmd  (cmd)
    );

    ona_dpath #(
        .CAPACITY (CAPACITY),
        .MAX_BATCH(MAX_BATCH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .name        (name),
        .count       (count),
        .strobe      (strobe),
        .out_name    (out_name),
        .status      (status),
        .is_live     (is_live),
        .current_name(current_name),
        .last        (last)
    );

endmodule

// File: hdl/ona_ram.sv
module ona_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/ona_ctrl.sv
module ona_ctrl
    import ona_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  ona_sts_t sts,
    output ona_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_GEN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.run_gen ? S_GEN : S_IDLE;
            end
            S_GEN:
            begin
                cmd.gen_step = 1'b1;
                if (sts.gen_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.exec)
        else $error("accepted command not executed next cycle");

endmodule

// File: hdl/ona_dpath.sv
module ona_dpath
    import ona_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int MAX_BATCH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ona_cmd_t   cmd,
    output ona_sts_t   sts,
    input  logic [1:0] func,
    input  logic [7:0] name,
    input  logic [4:0] count,
    output logic       strobe,
    output logic [7:0] out_name,
    output logic [1:0] status,
    output logic       is_live,
    output logic [7:0] current_name,
    output logic       last
);

    localparam int NAME_LIMIT = (CAPACITY < 256) ? CAPACITY : 256;
    localparam int LIVE_AW    = $clog2(NAME_LIMIT);
    localparam int LIVE_DEPTH = 1 << LIVE_AW;
    localparam int STK_AW     = $clog2(CAPACITY);
    localparam int FC_W       = $clog2(CAPACITY + 1);
    localparam logic [8:0]      LIMIT     = 9'(NAME_LIMIT);
    localparam logic [FC_W-1:0] FC_MAX    = FC_W'(CAPACITY);
    localparam logic [6:0]      BATCH_MAX = 7'(MAX_BATCH);

    logic [1:0]            func_reg, func_next;
    logic [7:0]            name_reg, name_next;
    logic [4:0]            count_reg, count_next;
    logic [FC_W-1:0]       fc_reg, fc_next;
    logic [8:0]            hw_reg, hw_next;
    logic [7:0]            bound_reg, bound_next;
    logic [LIVE_DEPTH-1:0] valid_reg, valid_next;
    logic                  strobe_reg, strobe_next;
    ona_res_t              res_reg, res_next;

    logic                  live_we;
    logic [LIVE_AW-1:0]    live_waddr;
    logic                  live_wdata;
    logic                  live_rdata;
    logic                  stk_we;
    logic [7:0]            stk_rdata;
    logic [FC_W-1:0]       fc_dec;

    logic                  live_cur;
    logic                  in_range;
    logic                  below_hw;
    logic                  count_ok;
    logic                  out_of_names;
    logic [7:0]            got;

    ona_ram #(
        .WIDTH(1),
        .DEPTH(LIVE_DEPTH)
    ) u_live_ram (
        .clk  (clk),
        .we   (live_we),
        .waddr(live_waddr),
        .wdata(live_wdata),
        .raddr(name[LIVE_AW-1:0]),
        .rdata(live_rdata)
    );

    assign fc_dec = fc_next - FC_W'(1);

    ona_ram #(
        .WIDTH(8),
        .DEPTH(CAPACITY)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stk_we),
        .waddr(fc_reg[STK_AW-1:0]),
        .wdata(name_reg),
        .raddr(fc_dec[STK_AW-1:0]),
        .rdata(stk_rdata)
    );

    // unwritten entries read as their reset value
    assign live_cur = valid_reg[name_reg[LIVE_AW-1:0]] ? live_rdata : (name_reg < 8'd2);
    assign in_range = ({1'b0, name_reg} < LIMIT);
    assign below_hw = ({1'b0, name_reg} < hw_reg);
    assign count_ok = (count_reg != 5'd0) && ({2'b00, count_reg} <= BATCH_MAX);
    assign out_of_names = (fc_reg == '0) && (hw_reg >= LIMIT);

    assign sts.run_gen = (func_t'(func_reg) == FUNC_GEN) && count_ok;
    assign sts.gen_end = out_of_names || (count_reg == 5'd1);

    always_comb
    begin
        func_next   = func_reg;
        name_next   = name_reg;
        count_next  = count_reg;
        fc_next     = fc_reg;
        hw_next     = hw_reg;
        bound_next  = bound_reg;
        valid_next  = valid_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        live_we     = 1'b0;
        live_waddr  = name_reg[LIVE_AW-1:0];
        live_wdata  = 1'b0;
        stk_we      = 1'b0;
        got         = stk_rdata;

        if (cmd.capture)
        begin
            func_next  = func;
            name_next  = name;
            count_next = count;
        end

        if (cmd.exec)
        begin
            res_next.out_name = name_reg;
            res_next.status   = ST_OK;
            res_next.is_live  = 1'b0;
            res_next.last     = 1'b1;
            case (func_t'(func_reg))
                FUNC_GEN:
                begin
                    if (!count_ok)
                    begin
                        strobe_next     = 1'b1;
                        res_next.status = ST_INVALID;
                    end
                end
                FUNC_BIND:
                begin
                    strobe_next = 1'b1;
                    if (!in_range)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        live_we    = 1'b1;
                        live_wdata = 1'b1;
                        valid_next[name_reg[LIVE_AW-1:0]] = 1'b1;
                        if (!live_cur && !below_hw)
                        begin
                            hw_next = {1'b0, name_reg} + 9'd1;
                        end
                        bound_next = name_reg;
                    end
                end
                FUNC_DELETE:
                begin
                    strobe_next = 1'b1;
                    if (name_reg == 8'd0 || !below_hw || !in_range || !live_cur)
                    begin
                        res_next.status = ST_IGNORED;
                    end
                    else
                    begin
                        live_we = 1'b1;
                        valid_next[name_reg[LIVE_AW-1:0]] = 1'b1;
                        if (bound_reg == name_reg)
                        begin
                            bound_next = 8'd0;
                        end
                        if (fc_reg < FC_MAX)
                        begin
                            stk_we  = 1'b1;
                            fc_next = fc_reg + FC_W'(1);
                        end
                        else
                        begin
                            res_next.status = ST_IGNORED;
                        end
                    end
                end
                default:
                begin
                    strobe_next      = 1'b1;
                    res_next.is_live = (name_reg != 8'd0) && below_hw && in_range && live_cur;
                end
            endcase
        end

        if (cmd.gen_step)
        begin
            strobe_next      = 1'b1;
            res_next.is_live = 1'b0;
            count_next       = count_reg - 5'd1;
            if (out_of_names)
            begin
                res_next.out_name = 8'd0;
                res_next.status   = ST_FULL;
                res_next.last     = 1'b1;
            end
            else
            begin
                if (fc_reg != '0)
                begin
                    got     = stk_rdata;
                    fc_next = fc_reg - FC_W'(1);
                end
                else
                begin
                    got     = hw_reg[7:0];
                    hw_next = hw_reg + 9'd1;
                end
                live_we    = 1'b1;
                live_wdata = 1'b1;
                live_waddr = got[LIVE_AW-1:0];
                valid_next[got[LIVE_AW-1:0]] = 1'b1;
                res_next.out_name = got;
                res_next.status   = ST_OK;
                res_next.last     = (count_reg == 5'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg     <= '0;
            hw_reg     <= 9'd2;
            bound_reg  <= 8'd1;
            valid_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            fc_reg     <= fc_next;
            hw_reg     <= hw_next;
            bound_reg  <= bound_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        name_reg  <= name_next;
        count_reg <= count_next;
        res_reg   <= res_next;
    end

    assign strobe       = strobe_reg;
    assign out_name     = res_reg.out_name;
    assign status       = res_reg.status;
    assign is_live      = res_reg.is_live;
    assign current_name = bound_reg;
    assign last         = res_reg.last;

    a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !res_reg.last |=> strobe_reg)
        else $error("generate run broken before its last beat");

    a_inv_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && res_reg.status == ST_INVALID |-> res_reg.last)
        else $error("invalid argument beat not marked last");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_MAX && hw_reg <= LIMIT && hw_reg >= 9'd2)
        else $error("free count or high-water out of range");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import ona_pkg::*;

    localparam int CAPACITY    = 256;
    localparam int MAX_BATCH   = 16;
    localparam int NAME_LIMIT  = (CAPACITY < 256) ? CAPACITY : 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        func_t      op;
        logic [7:0] nm;
        logic [4:0] count;
    } name_cmd_t;

    typedef struct {
        logic [7:0] out_name;
        status_t    st;
        logic       is_live;
        logic [7:0] current;
        logic       last;
    } name_beat_t;

    logic       clk;
    logic       rst_n;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] func  = 2'd0;
    logic [7:0] name  = 8'd0;
    logic [4:0] count = 5'd0;
    logic       strobe;
    logic [7:0] out_name;
    logic [1:0] status;
    logic       is_live;
    logic [7:0] current_name;
    logic       last;

    object_name_allocator #(
        .CAPACITY(CAPACITY),
        .MAX_BATCH(MAX_BATCH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .name(name),
        .count(count),
        .strobe(strobe),
        .out_name(out_name),
        .status(status),
        .is_live(is_live),
        .current_name(current_name),
        .last(last)
    );

    // allocator shadow state
    bit         name_live [256];
    logic [7:0] free_names [CAPACITY];
    int         free_top;
    int         high_water;
    logic [7:0] bound;

    name_cmd_t  pending_cmds [$];
    name_beat_t expected_beats [$];
    name_cmd_t  in_flight;
    name_beat_t next_beat;
    int         gap_left = 0;
    bit         idle_bursts = 1'b1;
    int         errors = 0;
    int         cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
        errors++;
    endtask

    task automatic push_beat(input logic [7:0] nm, input status_t st, input logic lv,
                             input logic lst);
        name_beat_t b;
        b.out_name = nm;
        b.st       = st;
        b.is_live  = lv;
        b.current  = bound;
        b.last     = lst;
        expected_beats.push_back(b);
    endtask

    task automatic reset_allocator();
        int i;
        for (i = 0; i < 256; i++)
            name_live[i] = 1'b0;
        name_live[0] = 1'b1;
        name_live[1] = 1'b1;
        free_top   = 0;
        high_water = 2;
        bound      = 8'd1;
    endtask

    task automatic apply_command(input name_cmd_t c);
        int         k;
        bit         exhausted;
        logic [7:0] got;
        exhausted = 1'b0;
        case (c.op)
            FUNC_GEN:
            begin
                if (c.count == 0 || c.count > MAX_BATCH)
                    push_beat(c.nm, ST_INVALID, 1'b0, 1'b1);
                else
                begin
                    for (k = 0; k < c.count && !exhausted; k++)
                    begin
                        if (free_top > 0)
                        begin
                            free_top--;
                            got = free_names[free_top];
                        end
                        else if (high_water < NAME_LIMIT)
                        begin
                            got = high_water[7:0];
                            high_water++;
                        end
                        else
                        begin
                            push_beat(8'd0, ST_FULL, 1'b0, 1'b1);
                            exhausted = 1'b1;
                        end
                        if (!exhausted)
                        begin
                            name_live[got] = 1'b1;
                            push_beat(got, ST_OK, 1'b0, k + 1 == c.count);
                        end
                    end
                end
            end
            FUNC_BIND:
            begin
                if (c.nm >= NAME_LIMIT)
                    push_beat(c.nm, ST_FULL, 1'b0, 1'b1);
                else
                begin
                    if (!name_live[c.nm])
                    begin
                        name_live[c.nm] = 1'b1;
                        if (c.nm >= high_water)
                            high_water = c.nm + 1;
                    end
                    bound = c.nm;
                    push_beat(c.nm, ST_OK, 1'b0, 1'b1);
                end
            end
            FUNC_DELETE:
            begin
                if (c.nm == 0 || c.nm >= high_water || c.nm >= NAME_LIMIT || !name_live[c.nm])
                    push_beat(c.nm, ST_IGNORED, 1'b0, 1'b1);
                else
                begin
                    name_live[c.nm] = 1'b0;
                    if (bound == c.nm)
                        bound = 8'd0;
                    if (free_top < CAPACITY)
                    begin
                        free_names[free_top] = c.nm;
                        free_top++;
                        push_beat(c.nm, ST_OK, 1'b0, 1'b1);
                    end
                    else
                        push_beat(c.nm, ST_IGNORED, 1'b0, 1'b1);
                end
            end
            default:
            begin
                push_beat(c.nm, ST_OK,
                          c.nm != 0 && c.nm < high_water && c.nm < NAME_LIMIT
                          && name_live[c.nm], 1'b1);
            end
        endcase
    endtask

    task automatic queue_cmd(input func_t op, input logic [7:0] nm, input logic [4:0] cnt);
        name_cmd_t c;
        c.op    = op;
        c.nm    = nm;
        c.count = cnt;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_beats.size() != 0 || start || busy)
            @(negedge clk);
    endtask

    // random commands; generate counts are held to the names that are surely left
    task automatic plan_chunk(input int n);
        int         i;
        int         r;
        int         hw0;
        int         pool;
        int         cost;
        logic [7:0] nm;
        logic [4:0] cnt;
        logic [7:0] live_names [$];
        hw0  = high_water;
        pool = free_top + NAME_LIMIT - high_water;
        for (i = 1; i < high_water; i++)
            if (name_live[i])
                live_names.push_back(8'(i));
        idle_bursts = ($urandom_range(0, 3) != 0);
        repeat (n)
        begin
            r   = $urandom_range(0, 99);
            nm  = 8'($urandom_range(0, 255));
            cnt = 5'($urandom_range(0, 31));
            if (r < 25)
            begin
                if ($urandom_range(0, 6) != 0)
                    cnt = ($urandom_range(0, 7) == 0) ? 5'(MAX_BATCH)
                                                      : 5'($urandom_range(1, 6));
                if (cnt >= 1 && cnt <= MAX_BATCH && cnt >= pool)
                    queue_cmd(FUNC_QUERY, nm, cnt);
                else
                begin
                    if (cnt >= 1 && cnt <= MAX_BATCH)
                        pool -= cnt;
                    queue_cmd(FUNC_GEN, nm, cnt);
                end
            end
            else if (r < 45)
            begin
                if ($urandom_range(0, 1))
                    nm = 8'($urandom_range(0, hw0 - 1));
                cost = int'(nm) + 1 - hw0;
                if (cost > 0)
                begin
                    if (pool - cost < 20)
                        nm = 8'($urandom_range(0, hw0 - 1));
                    else
                        pool -= cost;
                end
                queue_cmd(FUNC_BIND, nm, cnt);
            end
            else if (r < 80)
            begin
                if (live_names.size() > 0 && $urandom_range(0, 3) != 0)
                    nm = live_names[$urandom_range(0, live_names.size() - 1)];
                queue_cmd(FUNC_DELETE, nm, cnt);
            end
            else
            begin
                if ($urandom_range(0, 1))
                    nm = 8'($urandom_range(0, hw0 - 1));
                queue_cmd(FUNC_QUERY, nm, cnt);
            end
        end
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                apply_command(in_flight);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_flight = pending_cmds.pop_front();
                    func  <= in_flight.op;
                    name  <= in_flight.nm;
                    count <= in_flight.count;
                    start <= 1'b1;
                    if (idle_bursts && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 3);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("beat with nothing expected, out_name", out_name, -1);
            else
            begin
                next_beat = expected_beats.pop_front();
                if (out_name !== next_beat.out_name)
                    report_mismatch("out_name", out_name, next_beat.out_name);
                if (status !== next_beat.st)
                    report_mismatch("status", status, next_beat.st);
                if (is_live !== next_beat.is_live)
                    report_mismatch("is_live", is_live, next_beat.is_live);
                if (current_name !== next_beat.current)
                    report_mismatch("current_name", current_name, next_beat.current);
                if (last !== next_beat.last)
                    report_mismatch("last", last, next_beat.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        reset_allocator();
        while (!rst_n)
            @(negedge clk);

        // directed: field extremes and corner cases
        queue_cmd(FUNC_QUERY, 8'd0, 5'd0);
        queue_cmd(FUNC_QUERY, 8'd1, 5'd31);
        queue_cmd(FUNC_QUERY, 8'd255, 5'd16);
        queue_cmd(FUNC_GEN, 8'hA5, 5'd0);
        queue_cmd(FUNC_GEN, 8'h5A, 5'd17);
        queue_cmd(FUNC_GEN, 8'hFF, 5'd31);
        queue_cmd(FUNC_GEN, 8'd0, 5'd3);
        queue_cmd(FUNC_DELETE, 8'd0, 5'd0);
        queue_cmd(FUNC_DELETE, 8'd200, 5'd0);
        queue_cmd(FUNC_DELETE, 8'd3, 5'd0);
        queue_cmd(FUNC_DELETE, 8'd3, 5'd0);
        // rebind a freed name, then generate pops it while live
        queue_cmd(FUNC_BIND, 8'd3, 5'd0);
        queue_cmd(FUNC_GEN, 8'd0, 5'd2);
        queue_cmd(FUNC_BIND, 8'd4, 5'd0);
        queue_cmd(FUNC_DELETE, 8'd4, 5'd0);
        queue_cmd(FUNC_QUERY, 8'd4, 5'd0);
        queue_cmd(FUNC_BIND, 8'd130, 5'd0);
        queue_cmd(FUNC_QUERY, 8'd130, 5'd0);
        queue_cmd(FUNC_GEN, 8'd7, 5'd16);
        queue_cmd(FUNC_BIND, 8'd0, 5'd0);
        queue_cmd(FUNC_DELETE, 8'd1, 5'd0);
        queue_cmd(FUNC_QUERY, 8'd1, 5'd0);
        queue_cmd(FUNC_BIND, 8'd1, 5'd0);
        wait_idle();

        repeat (24)
        begin
            plan_chunk(10);
            wait_idle();
        end

        // drain the stack, then run out of names partway through a batch
        idle_bursts = 1'b0;
        repeat ((free_top + MAX_BATCH - 1) / MAX_BATCH)
            queue_cmd(FUNC_GEN, 8'($urandom_range(0, 255)), 5'(MAX_BATCH));
        wait_idle();
        if (high_water < 254)
            queue_cmd(FUNC_BIND, 8'd253, 5'd0);
        queue_cmd(FUNC_GEN, 8'($urandom_range(0, 255)), 5'(MAX_BATCH));
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/ona_pkg.sv
hdl/ona_ram.sv
hdl/ona_ctrl.sv
hdl/ona_dpath.sv
hdl/object_name_allocator.sv
test/tb.sv
